>>> hw/rtl/p3cs_pkg.sv
// Package for the POP3 credential sniffer.
// Holds the phase encoding, the result word type, the keyword tables and the
// byte folding helpers. No dependencies.
package p3cs_pkg;

  localparam int MAX_NAME = 64;
  localparam int CNT_W    = 7;

  localparam logic [7:0] CH_LF = 8'h0A;

  // Phase codes as they appear on the result port.
  localparam logic [2:0] CODE_GREET    = 3'd0;
  localparam logic [2:0] CODE_USER_KEY = 3'd1;
  localparam logic [2:0] CODE_USER_CAP = 3'd2;
  localparam logic [2:0] CODE_PASS_KEY = 3'd3;
  localparam logic [2:0] CODE_PASS_CAP = 3'd4;
  localparam logic [2:0] CODE_REPLY    = 3'd5;
  localparam logic [2:0] CODE_DONE     = 3'd6;

  typedef enum logic [6:0] {
    PH_GREET    = 7'b0000001,
    PH_USER_KEY = 7'b0000010,
    PH_USER_CAP = 7'b0000100,
    PH_PASS_KEY = 7'b0001000,
    PH_PASS_CAP = 7'b0010000,
    PH_REPLY    = 7'b0100000,
    PH_DONE     = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       capture_valid;
    logic       capture_kind;
    logic [7:0] capture_byte;
    logic       field_end;
    logic       truncated;
    logic       accepted;
    logic       rejected;
  } res_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_GREET:    code = CODE_GREET;
      PH_USER_KEY: code = CODE_USER_KEY;
      PH_USER_CAP: code = CODE_USER_CAP;
      PH_PASS_KEY: code = CODE_PASS_KEY;
      PH_PASS_CAP: code = CODE_PASS_CAP;
      PH_REPLY:    code = CODE_REPLY;
      default:     code = CODE_DONE;
    endcase
    return code;
  endfunction

  // Only the letters A-Z are folded to lower case.
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] f;
    if (c >= 8'h41 && c <= 8'h5A) begin
      f = c + 8'd32;
    end else begin
      f = c;
    end
    return f;
  endfunction

  function automatic logic same(input logic [7:0] a, input logic [7:0] b);
    return fold(a) == fold(b);
  endfunction

  function automatic logic [7:0] kw_ok(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h2B; // '+'
      3'd1:    c = 8'h4F; // 'O'
      default: c = 8'h4B; // 'K'
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_user(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h55; // 'U'
      3'd1:    c = 8'h53; // 'S'
      3'd2:    c = 8'h45; // 'E'
      3'd3:    c = 8'h52; // 'R'
      default: c = 8'h20; // ' '
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_pass(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h50; // 'P'
      3'd1:    c = 8'h41; // 'A'
      3'd2:    c = 8'h53; // 'S'
      3'd3:    c = 8'h53; // 'S'
      default: c = 8'h20; // ' '
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_err(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h2D; // '-'
      3'd1:    c = 8'h45; // 'E'
      default: c = 8'h52; // 'R'
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/pop3_credential_sniffer.sv
// POP3 credential sniffer. Takes one session byte per word and walks the
// greeting, USER, PASS and reply phases, emitting one result word per byte.
// Throughput is one byte per cycle while the result side does not stall. A byte
// is taken into the input register, then the phase logic writes its result word
// into the result register, from which the word is presented; a result-side stall
// holds the byte in the input register. Keyword compares fold A-Z to lower
// case; credential bytes are passed raw and cut off after MAX_NAME bytes per
// field. Depends on p3cs_pkg and p3cs_phase.
module pop3_credential_sniffer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_phase,
  output logic       out_capture_valid,
  output logic       out_capture_kind,
  output logic [7:0] out_capture_byte,
  output logic       out_field_end,
  output logic       out_truncated,
  output logic       out_accepted,
  output logic       out_rejected
);
  import p3cs_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  res_t       out_res_r;
  res_t       res;
  logic       adv;
  logic       in_take;

  // A byte moves into the result register when that register is empty or is
  // being emptied in the same cycle.
  assign adv     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take = in_valid && !in_stall;

  p3cs_phase u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (adv),
    .data_byte (in_byte_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_data_byte;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_phase         = out_res_r.phase;
  assign out_capture_valid = out_res_r.capture_valid;
  assign out_capture_kind  = out_res_r.capture_kind;
  assign out_capture_byte  = out_res_r.capture_byte;
  assign out_field_end     = out_res_r.field_end;
  assign out_truncated     = out_res_r.truncated;
  assign out_accepted      = out_res_r.accepted;
  assign out_rejected      = out_res_r.rejected;

endmodule

>>> hw/rtl/p3cs_phase.sv
// Session phase tracker of the POP3 credential sniffer: phase and match state
// registers plus the per-byte next-state and result logic.
// Depends on p3cs_pkg.
module p3cs_phase (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  logic [7:0]      data_byte,
  output p3cs_pkg::res_t  res
);
  import p3cs_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [2:0]         mpos_r, mpos_nxt;
  logic [2:0]         epos_r, epos_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    phase_nxt = phase_r;
    mpos_nxt  = mpos_r;
    epos_nxt  = epos_r;
    cnt_nxt   = cnt_r;
    res       = '0;

    case (phase_r)
      PH_GREET: begin
        if (mpos_r < 3'd3 && same(data_byte, kw_ok(mpos_r))) begin
          if (mpos_r == 3'd2) begin
            mpos_nxt  = 3'd0;
            phase_nxt = PH_USER_KEY;
          end else begin
            mpos_nxt = mpos_r + 3'd1;
          end
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_USER_KEY, PH_PASS_KEY: begin
        if (mpos_r < 3'd5 && same(data_byte, (phase_r == PH_PASS_KEY) ?
                                  kw_pass(mpos_r) : kw_user(mpos_r))) begin
          if (mpos_r == 3'd4) begin
            mpos_nxt  = 3'd0;
            cnt_nxt   = '0;
            phase_nxt = (phase_r == PH_PASS_KEY) ? PH_PASS_CAP : PH_USER_CAP;
          end else begin
            mpos_nxt = mpos_r + 3'd1;
          end
        end else begin
          // The mismatching byte is not retried as a first keyword byte.
          mpos_nxt = 3'd0;
        end
      end
      PH_USER_CAP, PH_PASS_CAP: begin
        res.capture_kind = (phase_r == PH_PASS_CAP);
        if (data_byte != CH_LF) begin
          if (cnt_r < CNT_W'(MAX_NAME)) begin
            cnt_nxt            = cnt_r + 1'b1;
            res.capture_valid  = 1'b1;
            res.capture_byte   = data_byte;
          end else begin
            res.truncated = 1'b1;
          end
        end else begin
          res.field_end = 1'b1;
          cnt_nxt       = '0;
          mpos_nxt      = 3'd0;
          epos_nxt      = 3'd0;
          phase_nxt     = (phase_r == PH_PASS_CAP) ? PH_REPLY : PH_PASS_KEY;
        end
      end
      PH_REPLY: begin
        // The +OK match takes priority; a miss leaves both matches as they are.
        if (mpos_r < 3'd3 && same(data_byte, kw_ok(mpos_r))) begin
          if (mpos_r == 3'd2) begin
            mpos_nxt     = 3'd0;
            res.accepted = 1'b1;
            phase_nxt    = PH_DONE;
          end else begin
            mpos_nxt = mpos_r + 3'd1;
          end
        end else if (epos_r < 3'd4 && same(data_byte, kw_err(epos_r))) begin
          if (epos_r == 3'd3) begin
            epos_nxt     = 3'd0;
            mpos_nxt     = 3'd0;
            res.rejected = 1'b1;
            phase_nxt    = PH_USER_KEY;
          end else begin
            epos_nxt = epos_r + 3'd1;
          end
        end
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    res.phase = phase_code(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_GREET;
      mpos_r  <= 3'd0;
      epos_r  <= 3'd0;
      cnt_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      mpos_r  <= mpos_nxt;
      epos_r  <= epos_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |=> phase_r == PH_DONE)
    else $error("left the done phase");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_NAME))
    else $error("capture count beyond the length limit");

  a_capture_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (res.capture_valid || res.truncated || res.field_end) |->
      (phase_r == PH_USER_CAP || phase_r == PH_PASS_CAP))
    else $error("capture event outside a capture phase");

  a_accept_done: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.accepted |=> phase_r == PH_DONE)
    else $error("acceptance did not end sniffing");

  a_reject_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res.rejected |=> phase_r == PH_USER_KEY && mpos_r == 3'd0 && epos_r == 3'd0)
    else $error("rejection did not restart the USER hunt cleanly");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for pop3_credential_sniffer: drives session bytes,
// predicts each result word with its own session tracker and checks the port.
// Depends on p3cs_pkg for the phase codes, the result type, CH_LF and MAX_NAME.
module testbench;
  import p3cs_pkg::*;

  localparam int RANDOM_BYTES = 1500;
  localparam int CYCLE_LIMIT  = 300000;

  typedef enum int {KEY_OK, KEY_USER, KEY_PASS, KEY_ERR} keyword_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_phase;
  logic       out_capture_valid;
  logic       out_capture_kind;
  logic [7:0] out_capture_byte;
  logic       out_field_end;
  logic       out_truncated;
  logic       out_accepted;
  logic       out_rejected;

  // Session tracker: the state the block should hold after every byte taken.
  logic [2:0] sess_phase = CODE_GREET;
  logic [2:0] kw_pos = 3'd0;
  logic [2:0] err_pos = 3'd0;
  logic [6:0] field_len = 7'd0;

  res_t expected_q[$];
  int   in_gap_pct = 0;
  int   stall_pct = 0;
  int   stall_left = 0;
  int   field_goal = -1;
  int   field_sent = 0;
  int   cycle_count = 0;
  int   mismatches = 0;
  int   bytes_sent = 0;
  int   words_checked = 0;
  int   n_captured = 0;
  int   n_dropped = 0;
  int   n_rejected = 0;
  int   n_accepted = 0;

  pop3_credential_sniffer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_phase         (out_phase),
    .out_capture_valid (out_capture_valid),
    .out_capture_kind  (out_capture_kind),
    .out_capture_byte  (out_capture_byte),
    .out_field_end     (out_field_end),
    .out_truncated     (out_truncated),
    .out_accepted      (out_accepted),
    .out_rejected      (out_rejected)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] key_char(input keyword_t k, input logic [2:0] pos);
    string w;
    case (k)
      KEY_OK:   w = "+OK";
      KEY_USER: w = "USER ";
      KEY_PASS: w = "PASS ";
      default:  w = "-ERR";
    endcase
    return w[pos];
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= "A" && c <= "Z") begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic [7:0] mix_case(input logic [7:0] c);
    if (to_lower(c) >= "a" && to_lower(c) <= "z" && $urandom_range(1) == 1) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  function automatic logic key_match(input logic [7:0] b, input keyword_t k,
                                     input logic [2:0] pos);
    return to_lower(b) == to_lower(key_char(k, pos));
  endfunction

  // Advances the session tracker by one byte and returns the word it causes.
  function automatic res_t track_session(input logic [7:0] b);
    res_t     r;
    keyword_t k;
    r = '0;
    case (sess_phase)
      CODE_GREET: begin
        if (kw_pos < 3'd3 && key_match(b, KEY_OK, kw_pos)) begin
          kw_pos = kw_pos + 3'd1;
          if (kw_pos == 3'd3) begin
            kw_pos = 3'd0;
            sess_phase = CODE_USER_KEY;
          end
        end else begin
          sess_phase = CODE_DONE;
        end
      end
      CODE_USER_KEY, CODE_PASS_KEY: begin
        k = (sess_phase == CODE_USER_KEY) ? KEY_USER : KEY_PASS;
        if (kw_pos < 3'd5 && key_match(b, k, kw_pos)) begin
          if (kw_pos == 3'd4) begin
            kw_pos = 3'd0;
            field_len = 7'd0;
            sess_phase = (k == KEY_USER) ? CODE_USER_CAP : CODE_PASS_CAP;
          end else begin
            kw_pos = kw_pos + 3'd1;
          end
        end else begin
          kw_pos = 3'd0;
        end
      end
      CODE_USER_CAP, CODE_PASS_CAP: begin
        r.capture_kind = (sess_phase == CODE_PASS_CAP);
        if (b != CH_LF) begin
          if (field_len < MAX_NAME) begin
            field_len = field_len + 7'd1;
            r.capture_valid = 1'b1;
            r.capture_byte = b;
            n_captured++;
          end else begin
            r.truncated = 1'b1;
            n_dropped++;
          end
        end else begin
          r.field_end = 1'b1;
          field_len = 7'd0;
          kw_pos = 3'd0;
          err_pos = 3'd0;
          sess_phase = r.capture_kind ? CODE_REPLY : CODE_PASS_KEY;
        end
      end
      CODE_REPLY: begin
        // The OK match has priority, and neither match is reset by a mismatch.
        if (kw_pos < 3'd3 && key_match(b, KEY_OK, kw_pos)) begin
          kw_pos = kw_pos + 3'd1;
          if (kw_pos == 3'd3) begin
            kw_pos = 3'd0;
            r.accepted = 1'b1;
            sess_phase = CODE_DONE;
            n_accepted++;
          end
        end else if (err_pos < 3'd4 && key_match(b, KEY_ERR, err_pos)) begin
          err_pos = err_pos + 3'd1;
          if (err_pos == 3'd4) begin
            err_pos = 3'd0;
            kw_pos = 3'd0;
            r.rejected = 1'b1;
            sess_phase = CODE_USER_KEY;
            n_rejected++;
          end
        end
      end
      default: sess_phase = CODE_DONE;
    endcase
    r.phase = sess_phase;
    return r;
  endfunction

  // Chooses the next byte so that most of the traffic forms sessions that
  // keep cycling through the login phases, with noise mixed in.
  function automatic logic [7:0] pick_byte(input bit allow_accept);
    logic [7:0] b;
    int         r;
    keyword_t   k;
    r = $urandom_range(99);
    case (sess_phase)
      CODE_USER_KEY, CODE_PASS_KEY: begin
        k = (sess_phase == CODE_USER_KEY) ? KEY_USER : KEY_PASS;
        if (r < 88) begin
          b = mix_case(key_char(k, kw_pos));
        end else if (r < 94) begin
          b = mix_case(key_char(k, 3'($urandom_range(4))));
        end else begin
          b = 8'($urandom_range(255));
        end
      end
      CODE_USER_CAP, CODE_PASS_CAP: begin
        if (field_goal < 0) begin
          field_goal = ($urandom_range(9) == 0) ? $urandom_range(70, 60) : $urandom_range(12);
        end
        if (field_sent >= field_goal) begin
          b = CH_LF;
          field_sent = 0;
          field_goal = -1;
        end else begin
          do begin
            b = 8'($urandom_range(255));
          end while (b == CH_LF);
          field_sent++;
        end
      end
      CODE_REPLY: begin
        if (r < 45) begin
          b = mix_case(key_char(KEY_ERR, err_pos));
        end else if (r < 60) begin
          b = mix_case(key_char(KEY_OK, kw_pos));
        end else begin
          b = 8'($urandom_range(255));
        end
        // An accepted login ends the session for good, so hold it back.
        if (!allow_accept && kw_pos == 3'd2 && to_lower(b) == "k") begin
          b = key_char(KEY_ERR, 3'd0);
        end
      end
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      gap = $urandom_range(9, 1);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(track_session(b));
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  // Receiver stalls come in bursts.
  always @(negedge clk) begin
    if (stall_left == 0 && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(9, 1);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp,
                             input logic [7:0] act);
    if (exp !== act) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result word with no byte pending, phase %0d", out_phase);
        mismatches++;
      end else begin
        exp = expected_q.pop_front();
        check_field("phase", 8'(exp.phase), 8'(out_phase));
        check_field("capture_valid", 8'(exp.capture_valid), 8'(out_capture_valid));
        check_field("capture_kind", 8'(exp.capture_kind), 8'(out_capture_kind));
        check_field("capture_byte", exp.capture_byte, out_capture_byte);
        check_field("field_end", 8'(exp.field_end), 8'(out_field_end));
        check_field("truncated", 8'(exp.truncated), 8'(out_truncated));
        check_field("accepted", 8'(exp.accepted), 8'(out_accepted));
        check_field("rejected", 8'(exp.rejected), 8'(out_rejected));
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Mixed-case greeting must be taken.
  task automatic test_greeting();
    send_text("+oK");
  endtask

  // The second U breaks the match and is not retried as a first letter.
  task automatic test_keyword_hunt();
    send_text("UUSER ");
    send_text("uSeR ");
  endtask

  // Extreme name bytes, then an empty password.
  task automatic test_field_extremes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_LF);
    send_text("pass ");
    send_byte(CH_LF);
  endtask

  // A partial OK match does not stop -ERR from rejecting.
  task automatic test_reply_mix();
    send_text("+-ERR");
  endtask

  task automatic test_truncation();
    send_text("USER ");
    field_goal = MAX_NAME + 2;
    while (sess_phase == CODE_USER_CAP) send_byte(pick_byte(1'b0));
    send_text("PASS ");
    field_goal = MAX_NAME;
    while (sess_phase == CODE_PASS_CAP) send_byte(pick_byte(1'b0));
    send_text("-ERR");
  endtask

  task automatic test_random_sessions();
    int sent;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if (sent % 150 == 0) begin
        in_gap_pct = 15 * $urandom_range(3);
        stall_pct = 15 * $urandom_range(3);
      end
      send_byte(pick_byte(1'b0));
      sent++;
    end
  endtask

  // Runs to a reply, lets the server accept, then feeds bytes into done.
  task automatic test_accept_and_done();
    in_gap_pct = 0;
    stall_pct = 0;
    while (sess_phase != CODE_REPLY) send_byte(pick_byte(1'b0));
    while (sess_phase != CODE_DONE) send_byte(mix_case(key_char(KEY_OK, kw_pos)));
    repeat (6) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    in_gap_pct = 20;
    stall_pct = 20;
    test_greeting();
    test_keyword_hunt();
    test_field_extremes();
    test_reply_mix();
    test_truncation();
    test_random_sessions();
    test_accept_and_done();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("Sent %0d session bytes and checked %0d result words.", bytes_sent,
             words_checked);
    $display("Captured %0d credential bytes, dropped %0d, %0d logins rejected, %0d accepted.",
             n_captured, n_dropped, n_rejected, n_accepted);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/p3cs_pkg.sv
hw/rtl/p3cs_phase.sv
hw/rtl/pop3_credential_sniffer.sv
test/testbench.sv
